### design/phs_pkg.sv
// phs_pkg: types, codes and the input range table for the pulse height spectrum block.
// No dependencies; every design file but phs_fifo refers to it by scoped names.
package phs_pkg;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic KIND_FILL = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] CFG_POLARITY   = 2'd0;
	localparam logic [1:0] CFG_RANGE      = 2'd1;
	localparam logic [1:0] CFG_FULL_SCALE = 2'd2;

	localparam int DIV_STEPS = 32;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] sample_value;
		logic               event_end;
		logic [7:0]         read_bin;
	} in_item_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [15:0] peak_code;
		logic [7:0]         bin_index;
		logic [31:0]        bin_count;
	} result_t;

	typedef struct packed {
		logic               is_read;
		logic signed [15:0] peak;
		logic [7:0]         read_bin;
	} task_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_BIN,
		BK_READ,
		BK_UPDATE
	} back_state_t;

	// input range in mV; indexes above the table saturate to the widest range
	function automatic logic [15:0] range_mv(input logic [3:0] sel);
		logic [15:0] mv;
		case (sel)
			4'd0: mv = 16'd10;
			4'd1: mv = 16'd20;
			4'd2: mv = 16'd50;
			4'd3: mv = 16'd100;
			4'd4: mv = 16'd200;
			4'd5: mv = 16'd500;
			4'd6: mv = 16'd1000;
			4'd7: mv = 16'd2000;
			4'd8: mv = 16'd5000;
			4'd9: mv = 16'd10000;
			4'd10: mv = 16'd20000;
			default: mv = 16'd50000;
		endcase
		return mv;
	endfunction

endpackage

### design/pulse_height_spectrum.sv
// Pulse height spectrum: samples stream at one per cycle while full is low; the running
// extremes are tracked in the front part. Each event end and each bin read becomes a task in
// a two-entry queue for the back part, which handles an event fill as one dispatch, one
// multiply, a 32-step serial divider, one bin clamp, a memory read and a read-modify-write,
// and a bin read as a dispatch, a memory read and a result push; full rises when that queue
// is full. After reset full stays high while the histogram memory is cleared one bin per
// cycle. Results wait in a two-entry queue until popped.
module pulse_height_spectrum #(
	parameter int BINS        = 200,
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  phs_pkg::in_item_t item,
	output logic              empty,
	input  logic              pop,
	output phs_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [14:0]       cfg_wdata
);

	logic        polarity_q;
	logic [3:0]  range_q;
	logic [14:0] full_scale_q;

	logic             accept;
	logic             clearing;
	logic             tq_full;
	logic             tq_empty;
	logic             tq_push;
	logic             tq_pop;
	phs_pkg::task_t   tq_wdata;
	phs_pkg::task_t   tq_rdata;
	logic             rq_full;
	logic             rq_push;
	phs_pkg::result_t rq_wdata;

	assign full   = tq_full | clearing;
	assign accept = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q   <= 1'b1;
			range_q      <= '0;
			full_scale_q <= 15'd32767;
		end else if (cfg_we) begin
			case (cfg_index)
				phs_pkg::CFG_POLARITY:   polarity_q   <= cfg_wdata[0];
				phs_pkg::CFG_RANGE:      range_q      <= cfg_wdata[3:0];
				phs_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	phs_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.item              (item),
		.polarity_negative (polarity_q),
		.task_push         (tq_push),
		.task_item         (tq_wdata)
	);

	phs_fifo #(
		.WIDTH ($bits(phs_pkg::task_t)),
		.DEPTH (2)
	) u_task_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tq_push),
		.wdata  (tq_wdata),
		.pop    (tq_pop),
		.rdata  (tq_rdata),
		.full   (tq_full),
		.empty  (tq_empty)
	);

	phs_back #(
		.BINS        (BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.task_valid     (~tq_empty),
		.task_item      (tq_rdata),
		.task_pop       (tq_pop),
		.res_ready      (~rq_full),
		.res_push       (rq_push),
		.res_item       (rq_wdata),
		.range_select   (range_q),
		.adc_full_scale (full_scale_q),
		.clearing       (clearing)
	);

	phs_fifo #(
		.WIDTH ($bits(phs_pkg::result_t)),
		.DEPTH (2)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wdata),
		.pop    (pop),
		.rdata  (result),
		.full   (rq_full),
		.empty  (empty)
	);

endmodule

### design/phs_fifo.sv
// phs_fifo: small register queue used between front and back and for results.
// Depends on nothing; payload is a flat vector.
module phs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### design/phs_front.sv
// phs_front: takes requests, tracks the event extremes and emits fill or read tasks.
// Depends on phs_pkg.
module phs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  phs_pkg::in_item_t item,
	input  logic              polarity_negative,
	output logic              task_push,
	output phs_pkg::task_t    task_item
);

	logic signed [15:0] max_q;
	logic signed [15:0] min_q;
	logic signed [15:0] new_max;
	logic signed [15:0] new_min;
	logic               is_sample;

	assign is_sample = (item.operation == phs_pkg::OP_SAMPLE);
	assign new_max   = (item.sample_value > max_q) ? item.sample_value : max_q;
	assign new_min   = (item.sample_value < min_q) ? item.sample_value : min_q;

	always_comb begin
		task_push          = accept & (~is_sample | item.event_end);
		task_item.is_read  = ~is_sample;
		task_item.read_bin = item.read_bin;
		if (!is_sample) begin
			task_item.peak = '0;
		end else if (polarity_negative) begin
			task_item.peak = new_min;
		end else begin
			task_item.peak = new_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			min_q <= '0;
		end else if (accept && is_sample) begin
			if (item.event_end) begin
				max_q <= '0;
				min_q <= '0;
			end else begin
				max_q <= new_max;
				min_q <= new_min;
			end
		end
	end

endmodule

### design/phs_back.sv
// phs_back: bins the peak (multiply, serial divide, clamp) and updates the histogram memory.
// Depends on phs_pkg; clears the memory after reset.
module phs_back #(
	parameter int BINS        = 200,
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              task_valid,
	input  phs_pkg::task_t    task_item,
	output logic              task_pop,
	input  logic              res_ready,
	output logic              res_push,
	output phs_pkg::result_t  res_item,
	input  logic [3:0]        range_select,
	input  logic [14:0]       adc_full_scale,
	output logic              clearing
);

	localparam int NB = BINS + 2;
	localparam int AW = $clog2(NB);
	localparam logic [AW-1:0] OVF_BIN = AW'(BINS + 1);

	phs_pkg::back_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0] mem [NB];
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic [63:0]            rd_ext;
	logic [63:0]            new_ext;

	phs_pkg::task_t task_q;
	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  clr_q;
	logic           in_range_q;
	logic           neg_q;
	logic [31:0]    dvd_q;
	logic [14:0]    rem_q;
	logic [4:0]     step_q;

	logic [14:0]        fs_eff;
	logic signed [16:0] rng17;
	logic signed [32:0] prod;
	logic [32:0]        prod_mag;
	logic [15:0]        rem_sh;
	logic               ge;
	logic [14:0]        rem_nx;
	logic [32:0]        qf;
	logic [AW-1:0]      bin_calc;
	logic [15:0]        rb16;
	logic               rb_in_range;
	logic [15:0]        addr16;
	logic               rd_en;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [COUNT_WIDTH-1:0] mem_wd;

	assign fs_eff   = (adc_full_scale == '0) ? 15'd1 : adc_full_scale;
	assign rng17    = $signed({1'b0, phs_pkg::range_mv(range_select)});
	assign prod     = task_q.peak * rng17;
	assign prod_mag = prod[32] ? 33'(-prod) : 33'(prod);

	assign rem_sh = {rem_q, dvd_q[31]};
	assign ge     = (rem_sh >= {1'b0, fs_eff});
	assign rem_nx = ge ? 15'(rem_sh - {1'b0, fs_eff}) : rem_sh[14:0];

	// floor of a negative quotient is minus the ceiling of the magnitude
	assign qf = {1'b0, dvd_q} + 33'(rem_q != '0);

	always_comb begin
		if (!neg_q) begin
			bin_calc = OVF_BIN;
		end else if (qf >= 33'(BINS + 1)) begin
			bin_calc = '0;
		end else if (qf == '0) begin
			bin_calc = OVF_BIN;
		end else begin
			bin_calc = OVF_BIN - qf[AW-1:0];
		end
	end

	assign rb16        = 16'(task_item.read_bin);
	assign rb_in_range = (rb16 < 16'(NB));
	assign addr16      = 16'(addr_q);

	assign cnt_new = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;
	assign rd_ext  = 64'(rd_data_q);
	assign new_ext = 64'(cnt_new);

	always_comb begin
		state_d = state_q;
		case (state_q)
			phs_pkg::BK_CLEAR: begin
				if (clr_q == OVF_BIN) state_d = phs_pkg::BK_IDLE;
			end
			phs_pkg::BK_IDLE: begin
				if (task_valid && res_ready) begin
					state_d = task_item.is_read ? phs_pkg::BK_READ : phs_pkg::BK_MUL;
				end
			end
			phs_pkg::BK_MUL: state_d = phs_pkg::BK_DIV;
			phs_pkg::BK_DIV: begin
				if (step_q == 5'(phs_pkg::DIV_STEPS - 1)) state_d = phs_pkg::BK_BIN;
			end
			phs_pkg::BK_BIN: state_d = phs_pkg::BK_READ;
			phs_pkg::BK_READ: state_d = phs_pkg::BK_UPDATE;
			phs_pkg::BK_UPDATE: state_d = phs_pkg::BK_IDLE;
			default: state_d = phs_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		task_pop = 1'b0;
		rd_en    = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = addr_q;
		mem_wd   = cnt_new;
		res_push = 1'b0;
		clearing = 1'b0;
		res_item.result_kind = phs_pkg::KIND_FILL;
		res_item.peak_code   = task_q.peak;
		res_item.bin_index   = addr16[7:0];
		res_item.bin_count   = new_ext[31:0];
		if (task_q.is_read) begin
			res_item.result_kind = phs_pkg::KIND_READ;
			res_item.peak_code   = '0;
			res_item.bin_index   = task_q.read_bin;
			res_item.bin_count   = in_range_q ? rd_ext[31:0] : 32'd0;
		end
		case (state_q)
			phs_pkg::BK_CLEAR: begin
				clearing = 1'b1;
				mem_we   = 1'b1;
				mem_wa   = clr_q;
				mem_wd   = '0;
			end
			phs_pkg::BK_IDLE: task_pop = task_valid & res_ready;
			phs_pkg::BK_READ: rd_en = ~task_q.is_read | in_range_q;
			phs_pkg::BK_UPDATE: begin
				res_push = 1'b1;
				mem_we   = ~task_q.is_read;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phs_pkg::BK_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == phs_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			phs_pkg::BK_IDLE: begin
				if (task_pop) begin
					task_q     <= task_item;
					addr_q     <= rb16[AW-1:0];
					in_range_q <= rb_in_range;
				end
			end
			phs_pkg::BK_MUL: begin
				neg_q  <= prod[32];
				dvd_q  <= {prod_mag[30:0], 1'b0};
				rem_q  <= '0;
				step_q <= '0;
			end
			phs_pkg::BK_DIV: begin
				dvd_q  <= {dvd_q[30:0], ge};
				rem_q  <= rem_nx;
				step_q <= step_q + 1'b1;
			end
			phs_pkg::BK_BIN: addr_q <= bin_calc;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en) rd_data_q <= mem[addr_q];
	end

endmodule

### design/phs_checker.sv
// phs_checker: port-level assertions on the result side of pulse_height_spectrum.
// Depends on phs_pkg; attached to the top level by the bind at the end of this file.
module phs_checker #(
	parameter int BINS = 200
) (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input phs_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == phs_pkg::KIND_FILL) |-> (result.bin_count != '0))
		else $error("filled bin reports zero count");

	a_fill_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == phs_pkg::KIND_FILL)
		|-> (16'(result.bin_index) <= 16'(BINS + 1)))
		else $error("filled bin index beyond overflow bin");

	a_read_beyond: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.result_kind == phs_pkg::KIND_READ
			&& 16'(result.bin_index) > 16'(BINS + 1))
		|-> (result.bin_count == '0 && result.peak_code == '0))
		else $error("read beyond last bin returned data");

endmodule

bind pulse_height_spectrum phs_checker #(.BINS(BINS)) u_phs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

### tb/sv/tb_top.sv
// tb_top: self-checking bench for pulse_height_spectrum. A directed table of requests and
// register writes comes first, then random events and bin reads, mostly under random idling.
// Depends on phs_pkg and the pulse_height_spectrum RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import phs_pkg::*;

	localparam int BINS          = 200;
	localparam int OVF_BIN       = BINS + 1;
	localparam int ITEM_W        = $bits(in_item_t);
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEM_TARGET   = 1850;
	localparam int PHASES        = 8;
	localparam int HOLD_AT       = 150;
	localparam int HOLD_CYCLES   = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	in_item_t    item      = '0;
	logic        empty;
	logic        pop       = 1'b0;
	result_t     result;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_POLARITY;
	logic [14:0] cfg_wdata = '0;

	pulse_height_spectrum u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// spectrum model: registers, running extremes, histogram
	bit          pol_neg    = 1'b1;
	logic [3:0]  range_sel  = 4'd0;
	logic [14:0] full_scale = 15'd32767;
	int          run_max    = 0;
	int          run_min    = 0;
	logic [31:0] hist [0:OVF_BIN] = '{default: '0};
	int          range_mv_tbl [12] = '{10, 20, 50, 100, 200, 500, 1000, 2000, 5000, 10000,
		20000, 50000};

	result_t owed_results [$];
	int      errors       = 0;
	int      results_seen = 0;
	int      sent         = 0;
	int      cycles       = 0;
	int      hold_left    = 0;
	bit      hold_done    = 1'b0;

	function automatic int peak_bin(input int pk);
		longint fs, num, q;
		int sel;
		sel = (range_sel > 11) ? 11 : int'(range_sel);
		fs = (full_scale == 0) ? 1 : longint'(full_scale);
		num = 2 * longint'(pk) * longint'(range_mv_tbl[sel]);
		q = num / fs;
		if (num % fs != 0 && num < 0) q = q - 1;
		q = q + OVF_BIN;
		if (q < 1) return 0;
		if (q > BINS) return OVF_BIN;
		return int'(q);
	endfunction

	function automatic bit spectrum_step(input in_item_t it, output result_t r);
		int s, pk, b;
		r = '0;
		if (it.operation == OP_READ) begin
			r.result_kind = KIND_READ;
			r.bin_index = it.read_bin;
			r.bin_count = (it.read_bin <= OVF_BIN) ? hist[it.read_bin] : '0;
			return 1'b1;
		end
		s = $signed(it.sample_value);
		if (s > run_max) run_max = s;
		if (s < run_min) run_min = s;
		if (it.event_end != 1'b1) return 1'b0;
		pk = pol_neg ? run_min : run_max;
		b = peak_bin(pk);
		if (hist[b] != '1) hist[b] = hist[b] + 32'd1;
		r.result_kind = KIND_FILL;
		r.peak_code = pk[15:0];
		r.bin_index = b[7:0];
		r.bin_count = hist[b];
		run_max = 0;
		run_min = 0;
		return 1'b1;
	endfunction

	function automatic void check_result(input result_t got);
		result_t want;
		if (owed_results.size() == 0) begin
			$display("%0t: unexpected result %p", $time, got);
			errors++;
			return;
		end
		want = owed_results.pop_front();
		results_seen++;
		if (got.result_kind !== want.result_kind) begin
			$display("%0t: result_kind expected %0d got %0d", $time, want.result_kind,
				got.result_kind);
			errors++;
		end
		if (got.peak_code !== want.peak_code) begin
			$display("%0t: peak_code expected %0d got %0d", $time, $signed(want.peak_code),
				$signed(got.peak_code));
			errors++;
		end
		if (got.bin_index !== want.bin_index) begin
			$display("%0t: bin_index expected %0d got %0d", $time, want.bin_index,
				got.bin_index);
			errors++;
		end
		if (got.bin_count !== want.bin_count) begin
			$display("%0t: bin_count expected %0d got %0d", $time, want.bin_count,
				got.bin_count);
			errors++;
		end
	endfunction

	// result side: random idling, one long hold-off, one stretch with no idling
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) check_result(result);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else if (results_seen >= 250 && results_seen < 400) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= 12);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_request(input in_item_t it, input bit has_typed, input result_t typed);
		result_t r;
		if (sent < 900 || sent >= 1300) begin
			while ($urandom_range(99) < 12) begin
				push <= 1'b0;
				item <= ITEM_W'($urandom);
				@(posedge clk);
			end
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		sent++;
		if (spectrum_step(it, r)) owed_results.insert(owed_results.size(), has_typed ? typed : r);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_reg(input logic [1:0] idx, input logic [14:0] data);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POLARITY:   pol_neg = data[0];
			CFG_RANGE:      range_sel = data[3:0];
			CFG_FULL_SCALE: full_scale = data;
			default: ;
		endcase
	endtask

	// mostly peaks that land inside the binned span for the current range
	function automatic logic [15:0] random_sample();
		int sel, fsv, lim, pick;
		sel = (range_sel > 11) ? 11 : int'(range_sel);
		fsv = (full_scale == 0) ? 1 : int'(full_scale);
		lim = fsv * 110 / range_mv_tbl[sel];
		if (lim > 32767) lim = 32767;
		if (lim < 1) lim = 1;
		pick = $urandom_range(99);
		if (pick < 70) return 16'(-$urandom_range(lim));
		if (pick < 85) return 16'($urandom_range(lim));
		return 16'($urandom);
	endfunction

	task automatic random_group();
		in_item_t it;
		int len;
		result_t none;
		none = '0;
		if ($urandom_range(99) < 20) begin
			it = ITEM_W'($urandom);
			it.operation = OP_READ;
			it.read_bin = ($urandom_range(99) < 90) ? 8'($urandom_range(OVF_BIN)) :
				8'($urandom);
			send_request(it, 1'b0, none);
		end else begin
			len = $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				it = ITEM_W'($urandom);
				it.operation = OP_SAMPLE;
				it.sample_value = random_sample();
				it.event_end = (k == len - 1);
				send_request(it, 1'b0, none);
			end
		end
	endtask

	typedef struct {
		bit          is_reg;
		logic [1:0]  reg_idx;
		logic [14:0] reg_data;
		in_item_t    req;
		bit          has_typed;
		result_t     typed;
	} plan_row_t;

	plan_row_t plan [$];

	function automatic void add_row(input plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	function automatic plan_row_t smp(input int v, input bit last);
		plan_row_t r;
		r = '{default: '0};
		r.req = ITEM_W'($urandom);
		r.req.operation = OP_SAMPLE;
		r.req.sample_value = 16'(v);
		r.req.event_end = last;
		return r;
	endfunction

	function automatic plan_row_t rd(input int b);
		plan_row_t r;
		r = '{default: '0};
		r.req = ITEM_W'($urandom);
		r.req.operation = OP_READ;
		r.req.read_bin = 8'(b);
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [1:0] idx, input int d);
		plan_row_t r;
		r = '{default: '0};
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_data = 15'(d);
		return r;
	endfunction

	function automatic plan_row_t with_result(input plan_row_t r, input int pk, input int b,
		input int cnt);
		r.has_typed = 1'b1;
		r.typed.result_kind = (r.req.operation == OP_READ) ? KIND_READ : KIND_FILL;
		r.typed.peak_code = 16'(pk);
		r.typed.bin_index = 8'(b);
		r.typed.bin_count = 32'(cnt);
		return r;
	endfunction

	initial begin
		int phase_end;
		bit pol;
		int rsel, fsc;

		add_row(with_result(rd(0), 0, 0, 0));
		add_row(with_result(rd(OVF_BIN), 0, OVF_BIN, 0));
		add_row(with_result(rd(255), 0, 255, 0));
		add_row(with_result(smp(0, 1), 0, OVF_BIN, 1));
		add_row(with_result(smp(32767, 1), 0, OVF_BIN, 2));
		add_row(smp(100, 0));
		add_row(smp(-500, 0));
		add_row(smp(7, 1));
		add_row(smp(-32768, 1));
		add_row(rd(180));
		add_row(rd(1));
		add_row(rd(BINS));
		add_row(reg_row(CFG_POLARITY, 0));
		add_row(with_result(smp(-32768, 1), 0, OVF_BIN, 3));
		add_row(smp(32767, 1));
		add_row(reg_row(CFG_RANGE, 11));
		add_row(reg_row(CFG_FULL_SCALE, 1));
		add_row(reg_row(CFG_POLARITY, 1));
		add_row(with_result(smp(-1, 1), -1, 0, 1));
		add_row(reg_row(CFG_FULL_SCALE, 0));
		add_row(with_result(smp(-2, 1), -2, 0, 2));
		add_row(reg_row(CFG_RANGE, 15));
		add_row(reg_row(CFG_FULL_SCALE, 32767));
		add_row(smp(-32768, 1));
		add_row(with_result(rd(0), 0, 0, 3));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// histogram clear pass after reset
		do @(posedge clk); while (full !== 1'b0);

		foreach (plan[i]) begin
			if (plan[i].is_reg) apply_reg(plan[i].reg_idx, plan[i].reg_data);
			else send_request(plan[i].req, plan[i].has_typed, plan[i].typed);
		end

		for (int p = 0; sent < ITEM_TARGET; p++) begin
			case (p)
				0: begin pol = 1'b1; rsel = 0;  fsc = 32767; end
				1: begin pol = 1'b0; rsel = 11; fsc = 1;     end
				2: begin pol = 1'b1; rsel = 12; fsc = 32767; end
				default: begin
					pol = $urandom_range(1);
					rsel = $urandom_range(15);
					fsc = ($urandom_range(1) != 0) ? $urandom_range(32767) :
						$urandom_range(1, 2000);
				end
			endcase
			apply_reg(CFG_POLARITY, 15'(pol));
			apply_reg(CFG_RANGE, 15'(rsel));
			apply_reg(CFG_FULL_SCALE, 15'(fsc));
			phase_end = sent + (ITEM_TARGET - plan.size()) / PHASES;
			while (sent < phase_end && sent < ITEM_TARGET) random_group();
		end

		settle();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
